[rtl/core/ial_pkg.sv]
// shared types for the indexed array list engine
// operation and status codes, sequencer states and the result bundle
package ial_pkg;

  typedef enum logic [2:0] {
    OP_INSERT  = 3'd0,
    OP_DELETE  = 3'd1,
    OP_REVERSE = 3'd2,
    OP_SEARCH  = 3'd3,
    OP_READ    = 3'd4
  } op_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_RANGE = 2'd2
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SHUP,
    S_INSW,
    S_SHDN,
    S_SRCH,
    S_RD1,
    S_RD2,
    S_REVR,
    S_REVW1,
    S_REVW2,
    S_DONE
  } state_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] read_value;
    logic        found;
    logic [5:0]  found_index;
    logic [6:0]  count;
  } res_t;

endpackage

[rtl/core/ial_ram.sv]
// element store: one write port, two registered read ports
// no dependencies
module ial_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  parameter int AW    = 6
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr_a,
  input  logic [AW-1:0]    raddr_b,
  output logic [WIDTH-1:0] rdata_a,
  output logic [WIDTH-1:0] rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

[rtl/core/ial_seq.sv]
// operation sequencer: walks the element store one entry per cycle
// uses ial_pkg; drives the ports of ial_ram
module ial_seq #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32,
  parameter int AW         = 6,
  parameter int LW         = 7
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  logic [2:0]            in_op,
  input  logic [6:0]            in_position,
  input  logic [31:0]           in_value,
  output logic                  res_valid,
  input  logic                  res_ready,
  output ial_pkg::res_t         res,
  output logic                  we,
  output logic [AW-1:0]         waddr,
  output logic [ELEM_WIDTH-1:0] wdata,
  output logic                  re,
  output logic [AW-1:0]         raddr_a,
  output logic [AW-1:0]         raddr_b,
  input  logic [ELEM_WIDTH-1:0] rdata_a,
  input  logic [ELEM_WIDTH-1:0] rdata_b
);
  import ial_pkg::*;

  localparam int CW = (LW > 7) ? LW : 7;

  state_t                state_r, state_nxt;
  logic [LW-1:0]         length_r, length_nxt;
  logic [AW-1:0]         ptr_r, ptr_nxt;
  logic [AW-1:0]         hi_r, hi_nxt;
  logic [AW-1:0]         paddr_r, paddr_nxt;
  logic [AW-1:0]         pos_r, pos_nxt;
  logic                  more_r, more_nxt;
  logic                  pend_r, pend_nxt;
  logic [ELEM_WIDTH-1:0] val_r, val_nxt;
  status_t               status_r, status_nxt;
  logic [31:0]           rd_r, rd_nxt;
  logic                  found_r, found_nxt;
  logic [5:0]            fidx_r, fidx_nxt;
  logic [CW-1:0]         pos_c;
  logic [CW-1:0]         len_c;
  logic [AW-1:0]         last_addr;

  assign pos_c     = CW'(in_position);
  assign len_c     = CW'(length_r);
  assign last_addr = AW'(length_r - 1'b1);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      length_r <= '0;
      more_r   <= 1'b0;
      pend_r   <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      length_r <= length_nxt;
      more_r   <= more_nxt;
      pend_r   <= pend_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ptr_r    <= ptr_nxt;
    hi_r     <= hi_nxt;
    paddr_r  <= paddr_nxt;
    pos_r    <= pos_nxt;
    val_r    <= val_nxt;
    status_r <= status_nxt;
    rd_r     <= rd_nxt;
    found_r  <= found_nxt;
    fidx_r   <= fidx_nxt;
  end

  always_comb begin
    state_nxt  = state_r;
    length_nxt = length_r;
    ptr_nxt    = ptr_r;
    hi_nxt     = hi_r;
    paddr_nxt  = paddr_r;
    pos_nxt    = pos_r;
    more_nxt   = more_r;
    pend_nxt   = pend_r;
    val_nxt    = val_r;
    status_nxt = status_r;
    rd_nxt     = rd_r;
    found_nxt  = found_r;
    fidx_nxt   = fidx_r;
    we         = 1'b0;
    waddr      = '0;
    wdata      = '0;
    re         = 1'b0;
    raddr_a    = ptr_r;
    raddr_b    = hi_r;
    in_ready   = 1'b0;
    res_valid  = 1'b0;

    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          status_nxt = ST_OK;
          rd_nxt     = '0;
          found_nxt  = 1'b0;
          fidx_nxt   = '0;
          pos_nxt    = AW'(in_position);
          val_nxt    = ELEM_WIDTH'(in_value);
          pend_nxt   = 1'b0;
          more_nxt   = 1'b1;
          case (in_op)
            OP_INSERT: begin
              if (len_c >= CW'(CAPACITY)) begin
                status_nxt = ST_FULL;
                state_nxt  = S_DONE;
              end else if (pos_c > len_c) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else if (pos_c == len_c) begin
                state_nxt = S_INSW;
              end else begin
                ptr_nxt   = last_addr;
                state_nxt = S_SHUP;
              end
            end
            OP_DELETE: begin
              if (pos_c >= len_c) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else if (CW'(pos_c + 1'b1) == len_c) begin
                length_nxt = LW'(length_r - 1'b1);
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = AW'(AW'(in_position) + 1'b1);
                state_nxt = S_SHDN;
              end
            end
            OP_REVERSE: begin
              if (length_r > LW'(1)) begin
                ptr_nxt   = '0;
                hi_nxt    = last_addr;
                state_nxt = S_REVR;
              end else begin
                state_nxt = S_DONE;
              end
            end
            OP_SEARCH: begin
              if (length_r == '0) begin
                state_nxt = S_DONE;
              end else begin
                ptr_nxt   = '0;
                state_nxt = S_SRCH;
              end
            end
            OP_READ: begin
              if (pos_c >= len_c) begin
                status_nxt = ST_RANGE;
                state_nxt  = S_DONE;
              end else begin
                ptr_nxt   = AW'(in_position);
                state_nxt = S_RD1;
              end
            end
            default: begin
              status_nxt = ST_RANGE;
              state_nxt  = S_DONE;
            end
          endcase
        end
      end
      S_SHUP: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = AW'(paddr_r + 1'b1);
          wdata = rdata_a;
        end
        if (more_r) begin
          re        = 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          if (ptr_r == pos_r) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = AW'(ptr_r - 1'b1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_INSW;
        end
      end
      S_INSW: begin
        we         = 1'b1;
        waddr      = pos_r;
        wdata      = val_r;
        length_nxt = LW'(length_r + 1'b1);
        state_nxt  = S_DONE;
      end
      S_SHDN: begin
        if (pend_r) begin
          we    = 1'b1;
          waddr = AW'(paddr_r - 1'b1);
          wdata = rdata_a;
        end
        if (more_r) begin
          re        = 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          if (ptr_r == last_addr) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = AW'(ptr_r + 1'b1);
          end
        end else begin
          pend_nxt   = 1'b0;
          length_nxt = LW'(length_r - 1'b1);
          state_nxt  = S_DONE;
        end
      end
      S_SRCH: begin
        if (pend_r && (rdata_a == val_r)) begin
          found_nxt = 1'b1;
          fidx_nxt  = 6'(paddr_r);
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end else if (more_r) begin
          re        = 1'b1;
          pend_nxt  = 1'b1;
          paddr_nxt = ptr_r;
          if (ptr_r == last_addr) begin
            more_nxt = 1'b0;
          end else begin
            ptr_nxt = AW'(ptr_r + 1'b1);
          end
        end else begin
          pend_nxt  = 1'b0;
          state_nxt = S_DONE;
        end
      end
      S_RD1: begin
        re        = 1'b1;
        state_nxt = S_RD2;
      end
      S_RD2: begin
        rd_nxt    = 32'(rdata_a);
        state_nxt = S_DONE;
      end
      S_REVR: begin
        re        = 1'b1;
        state_nxt = S_REVW1;
      end
      S_REVW1: begin
        we        = 1'b1;
        waddr     = ptr_r;
        wdata     = rdata_b;
        state_nxt = S_REVW2;
      end
      S_REVW2: begin
        we      = 1'b1;
        waddr   = hi_r;
        wdata   = rdata_a;
        ptr_nxt = AW'(ptr_r + 1'b1);
        hi_nxt  = AW'(hi_r - 1'b1);
        // next pair is read while the upper half of this one is written
        if (LW'(LW'(hi_r) - LW'(ptr_r)) > LW'(2)) begin
          re        = 1'b1;
          raddr_a   = AW'(ptr_r + 1'b1);
          raddr_b   = AW'(hi_r - 1'b1);
          state_nxt = S_REVW1;
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status      = status_r;
    res.read_value  = rd_r;
    res.found       = found_r;
    res.found_index = fidx_r;
    res.count       = 7'(length_r);
  end

endmodule

[rtl/core/indexed_array_list_engine.sv]
// indexed array list engine: top level with result register
// uses ial_pkg, ial_seq and ial_ram
//
//  channel | direction | ports                                          | beat
//  in      | input     | in_op, in_position, in_value                   | in_valid & in_ready
//  out     | output    | out_status, out_read_value, out_found,          | out_valid & out_ready
//          |           | out_found_index, out_count                     |
//
// one beat at a time: insert and delete shift the entries behind the position, read looks up one entry
// search walks up from index 0 and stops at the first match; reverse swaps entries pairwise from both ends
// rejected beats, inserts at the end, deletes of the last entry, a reverse of under two entries
// and a search of an empty list skip the walk; the single-write-port store is walked one entry a cycle
// rst_n clears the list length and control; element contents are not cleared
// a finished result waits in the output register while the next beat is taken
module indexed_array_list_engine #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  in_op,
  input  logic [6:0]  in_position,
  input  logic [31:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_status,
  output logic [31:0] out_read_value,
  output logic        out_found,
  output logic [5:0]  out_found_index,
  output logic [6:0]  out_count
);
  import ial_pkg::*;

  localparam int AW = $clog2(CAPACITY);
  localparam int LW = $clog2(CAPACITY + 1);

  res_t                  res;
  logic                  res_valid;
  logic                  res_ready;
  logic                  we;
  logic [AW-1:0]         waddr;
  logic [ELEM_WIDTH-1:0] wdata;
  logic                  re;
  logic [AW-1:0]         raddr_a;
  logic [AW-1:0]         raddr_b;
  logic [ELEM_WIDTH-1:0] rdata_a;
  logic [ELEM_WIDTH-1:0] rdata_b;
  logic                  out_valid_r, out_valid_nxt;
  res_t                  out_res_r, out_res_nxt;

  ial_seq #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH),
    .AW        (AW),
    .LW        (LW)
  ) u_seq (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_op      (in_op),
    .in_position(in_position),
    .in_value   (in_value),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res),
    .we         (we),
    .waddr      (waddr),
    .wdata      (wdata),
    .re         (re),
    .raddr_a    (raddr_a),
    .raddr_b    (raddr_b),
    .rdata_a    (rdata_a),
    .rdata_b    (rdata_b)
  );

  ial_ram #(
    .DEPTH(CAPACITY),
    .WIDTH(ELEM_WIDTH),
    .AW   (AW)
  ) u_ram (
    .clk    (clk),
    .we     (we),
    .waddr  (waddr),
    .wdata  (wdata),
    .re     (re),
    .raddr_a(raddr_a),
    .raddr_b(raddr_b),
    .rdata_a(rdata_a),
    .rdata_b(rdata_b)
  );

  assign res_ready = !out_valid_r || out_ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    out_res_nxt   = out_res_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
      out_res_nxt   = res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r <= out_res_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_status      = out_res_r.status;
  assign out_read_value  = out_res_r.read_value;
  assign out_found       = out_res_r.found;
  assign out_found_index = out_res_r.found_index;
  assign out_count       = out_res_r.count;

endmodule

[bench/tb_indexed_array_list_engine.sv]
`timescale 1ns / 1ps
// self-checking bench for indexed_array_list_engine: list edits, reverse, search and read
// depends on ial_pkg and the engine rtl; expected beats come from an in-bench list model

module tb_indexed_array_list_engine;
  import ial_pkg::*;

  localparam int LIST_CAPACITY = 64;
  localparam int ELEM_BITS = 32;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_CODE_MAX = 3'd7;
  localparam int RANDOM_BEATS = 360;
  localparam int SETTLE_CYCLES = 100;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [2:0]  in_op;
  logic [6:0]  in_position;
  logic [31:0] in_value;
  logic        out_valid;
  logic        out_ready;
  logic [1:0]  out_status;
  logic [31:0] out_read_value;
  logic        out_found;
  logic [5:0]  out_found_index;
  logic [6:0]  out_count;

  logic [31:0] list_cells [LIST_CAPACITY];
  int          list_len;
  res_t        pending_results [$];
  int          mismatches;
  int          send_idle_pct;
  int          recv_stall_pct;

  indexed_array_list_engine #(
    .CAPACITY   (LIST_CAPACITY),
    .ELEM_WIDTH (ELEM_BITS)
  ) u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_op           (in_op),
    .in_position     (in_position),
    .in_value        (in_value),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_status      (out_status),
    .out_read_value  (out_read_value),
    .out_found       (out_found),
    .out_found_index (out_found_index),
    .out_count       (out_count)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #(40_000_000);
    $display("simulation failed");
    $finish;
  end

  function automatic res_t apply_list_op(input logic [2:0] op, input logic [6:0] pos,
                                         input logic [31:0] val);
    res_t        r;
    int          k;
    int          lo;
    int          hi;
    logic [31:0] t;
    r = '0;
    case (op)
      OP_INSERT: begin
        if (list_len >= LIST_CAPACITY) begin
          r.status = ST_FULL;
        end else if (pos > list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = list_len; k > pos; k--) list_cells[k] = list_cells[k - 1];
          list_cells[pos] = val;
          list_len++;
        end
      end
      OP_DELETE: begin
        if (list_len == 0 || pos >= list_len) begin
          r.status = ST_RANGE;
        end else begin
          for (k = pos; k + 1 < list_len; k++) list_cells[k] = list_cells[k + 1];
          list_len--;
        end
      end
      OP_REVERSE: begin
        lo = 0;
        hi = list_len - 1;
        while (lo < hi) begin
          t = list_cells[lo];
          list_cells[lo] = list_cells[hi];
          list_cells[hi] = t;
          lo++;
          hi--;
        end
      end
      OP_SEARCH: begin
        for (k = 0; k < list_len; k++) begin
          if (list_cells[k] == val) begin
            r.found = 1'b1;
            r.found_index = 6'(k);
            break;
          end
        end
      end
      OP_READ: begin
        if (pos >= list_len) r.status = ST_RANGE;
        else r.read_value = list_cells[pos];
      end
      default: r.status = ST_RANGE;
    endcase
    r.count = 7'(list_len);
    return r;
  endfunction

  function automatic void log_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("mismatch at %0t: %s", $realtime, msg);
  endfunction

  // result beat checker
  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        log_mismatch("result beat with nothing outstanding");
      end else begin
        want = pending_results.pop_front();
        if (out_status !== want.status || out_read_value !== want.read_value ||
            out_found !== want.found || out_found_index !== want.found_index ||
            out_count !== want.count) begin
          log_mismatch($sformatf({"exp status %0d read %h found %0d idx %0d count %0d, ",
                                  "got status %0d read %h found %0d idx %0d count %0d"},
                                 want.status, want.read_value, want.found, want.found_index,
                                 want.count, out_status, out_read_value, out_found,
                                 out_found_index, out_count));
        end
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      out_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  task automatic send_beat(input logic [2:0] op, input logic [6:0] pos, input logic [31:0] val);
    @(negedge clk);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid    <= 1'b1;
    in_op       <= op;
    in_position <= pos;
    in_value    <= val;
    do @(posedge clk); while (!in_ready);
    pending_results.push_back(apply_list_op(op, pos, val));
  endtask

  task automatic wait_results_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  function automatic logic [6:0] pick_position(input logic [2:0] op);
    int top;
    top = (op == OP_INSERT) ? list_len : list_len - 1;
    if (top < 0 || $urandom_range(0, 99) < 20) return 7'($urandom_range(0, 127));
    case ($urandom_range(0, 3))
      0: return 7'd0;
      1: return 7'(top);
      default: return 7'($urandom_range(0, top));
    endcase
  endfunction

  function automatic logic [31:0] pick_value(input logic [2:0] op);
    if (op == OP_SEARCH && list_len > 0 && $urandom_range(0, 99) < 70)
      return list_cells[$urandom_range(0, list_len - 1)];
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3, 4: return 32'($urandom_range(0, 7));
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [2:0] pick_op(input bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 68) return OP_INSERT;
      if (r < 76) return OP_DELETE;
    end else begin
      if (r < 12) return OP_INSERT;
      if (r < 76) return OP_DELETE;
    end
    if (r < 82) return OP_REVERSE;
    if (r < 90) return OP_SEARCH;
    if (r < 98) return OP_READ;
    return 3'($urandom_range(OP_FIRST_UNUSED, OP_CODE_MAX));
  endfunction

  task automatic test_empty_list();
    send_beat(OP_READ, 7'd0, '0);
    send_beat(OP_DELETE, 7'd0, '0);
    send_beat(OP_REVERSE, 7'd0, '0);
    send_beat(OP_SEARCH, 7'd0, '0);
    send_beat(OP_INSERT, 7'd1, 32'h1);
  endtask

  task automatic test_edit_positions();
    send_beat(OP_INSERT, 7'd0, '1);
    send_beat(OP_READ, 7'd0, '0);
    send_beat(OP_INSERT, 7'd1, '0);
    send_beat(OP_INSERT, 7'd0, 32'h8000_0001);
    send_beat(OP_INSERT, 7'd1, 32'h0000_1234);
    send_beat(OP_REVERSE, 7'd0, '0);
    send_beat(OP_SEARCH, 7'd0, '0);
    send_beat(OP_SEARCH, 7'd0, '1);
    send_beat(OP_SEARCH, 7'd0, 32'h55);
    send_beat(OP_DELETE, 7'd3, '0);
    send_beat(OP_DELETE, 7'd0, '0);
    send_beat(OP_REVERSE, 7'd0, '0);
    send_beat(OP_READ, 7'd1, '0);
  endtask

  task automatic test_bad_requests();
    send_beat(OP_READ, 7'd127, '0);
    send_beat(OP_DELETE, 7'd127, '0);
    send_beat(OP_INSERT, 7'd127, 32'hA5A5_5A5A);
    send_beat(OP_FIRST_UNUSED, 7'd0, '1);
    send_beat(OP_FIRST_UNUSED + 3'd1, 7'd127, '0);
    send_beat(OP_CODE_MAX, 7'($urandom_range(0, 127)), $urandom());
    send_beat(OP_DELETE, 7'd0, '0);
    send_beat(OP_DELETE, 7'd0, '0);
  endtask

  // alternates between growing to full and shrinking to empty
  task automatic test_fill_drain_traffic(input int beats, input int idle_pct,
                                         input int stall_pct);
    bit          filling;
    logic [2:0]  op;
    logic [6:0]  pos;
    logic [31:0] val;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    filling = 1'b1;
    for (int i = 0; i < beats; i++) begin
      if (list_len == LIST_CAPACITY && $urandom_range(0, 3) == 0) filling = 1'b0;
      if (list_len == 0) filling = 1'b1;
      if (i == beats / 2) wait_results_drained();
      op  = pick_op(filling);
      pos = pick_position(op);
      val = pick_value(op);
      send_beat(op, pos, val);
    end
    wait_results_drained();
  endtask

  initial begin
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_op          = OP_INSERT;
    in_position    = '0;
    in_value       = '0;
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    mismatches     = 0;
    list_len       = 0;
    foreach (list_cells[k]) list_cells[k] = '0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_empty_list();
    test_edit_positions();
    test_bad_requests();
    wait_results_drained();
    test_fill_drain_traffic(RANDOM_BEATS, 0, 0);
    test_fill_drain_traffic(RANDOM_BEATS, 61, 0);
    test_fill_drain_traffic(RANDOM_BEATS, 0, 61);
    test_fill_drain_traffic(RANDOM_BEATS, 12, 12);

    repeat (SETTLE_CYCLES) @(posedge clk);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
